>>> hw/rtl/tkbsr_pkg.sv
package tkbsr_pkg;

    localparam int MAX_RANKED     = 8;
    localparam int SUM_WIDTH      = 36;
    localparam int ID_WIDTH       = 16;
    localparam int AMOUNT_WIDTH   = 32;
    localparam int K_WIDTH        = 4;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    localparam int S_TDATA_WIDTH = ((AMOUNT_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((ID_WIDTH + SUM_WIDTH + 7) / 8) * 8;

    // word index of each register (byte address / 4)
    localparam logic [APB_ADDR_WIDTH-3:0] REG_K_IN_USE = '0;

    localparam logic [K_WIDTH-1:0] K_RESET = K_WIDTH'(8);

    typedef logic [SUM_WIDTH-1:0] t_sum;
    typedef logic [ID_WIDTH-1:0]  t_id;

    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic rank;     // transfer closes a block
        logic shift;    // report transfer, chain moves toward cell 0
    } t_cell_ctl;

endpackage

>>> hw/rtl/tkbsr_cell.sv
module tkbsr_cell
    import tkbsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_in_k,
    input  t_sum      i_new_sum,
    input  t_id       i_new_id,
    input  logic      i_prev_gt,
    input  logic      i_prev_valid,
    input  t_sum      i_prev_sum,
    input  t_id       i_prev_id,
    input  logic      i_next_valid,
    input  t_sum      i_next_sum,
    input  t_id       i_next_id,
    output logic      o_gt,
    output logic      o_valid,
    output t_sum      o_sum,
    output t_id       o_id
);

    logic r_valid;
    logic n_valid;
    t_sum r_sum;
    t_sum n_sum;
    t_id  r_id;
    t_id  n_id;
    logic w_eff_valid;
    t_sum w_held;
    logic w_gt;

    // slots beyond k count as empty
    assign w_eff_valid = r_valid && i_in_k;
    assign w_held      = w_eff_valid ? r_sum : '0;
    assign w_gt        = i_in_k && (i_new_sum > w_held);

    assign o_gt    = w_gt;
    assign o_valid = w_eff_valid;
    assign o_sum   = r_sum;
    assign o_id    = r_id;

    always_comb begin
        n_valid = r_valid;
        n_sum   = r_sum;
        n_id    = r_id;
        if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_sum   = i_next_sum;
            n_id    = i_next_id;
        end else if (i_ctl.accept) begin
            n_valid = w_eff_valid;
            if (i_ctl.rank && w_gt) begin
                // gt is monotonic along the row: a cell whose left neighbor
                // also wins takes the neighbor's entry, the first winner
                // takes the new sum
                n_valid = w_eff_valid || i_prev_valid;
                if (i_prev_gt) begin
                    n_sum = i_prev_sum;
                    n_id  = i_prev_id;
                end else begin
                    n_sum = i_new_sum;
                    n_id  = i_new_id;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_id  <= n_id;
    end

endmodule

>>> hw/rtl/top_k_block_sum_ranker.sv
// top-k block sum ranker
// input stream: s_axis_tdata carries one transaction amount (unsigned, 8
// fraction bits), s_axis_tuser[0] marks the last transaction of a block and
// s_axis_tlast the last transaction of the run. amounts of a block are summed
// with saturation, blocks are numbered from 1 and each closed block is
// inserted into a descending row of up to k_in_use ranked cells in the cycle
// of its transfer (one compare per cell, shift toward the tail).
// output stream: after the run's last transfer the row is reported from the
// top, one entry per transfer; tuser[0] is 1 for a ranked entry, and an empty
// row gives one transfer with tuser 0, zero data and tlast set.
// throughput: one input transfer per cycle while no report is pending. the
// first report transfer is offered in the cycle after the tlast input
// transfer; a report of n entries (n at least 1) takes n output transfers, and
// the input side holds s_axis_tready low until
// the final report transfer. a stalled report holds its data; the row moves
// one cell up per completed output transfer and is empty again afterwards.
// k_in_use sits at byte address 0 of the apb port, reset value 8; 0 acts as
// 1 and values above 8 act as 8. reset empties the row and the accumulator,
// no clearing pass is needed.
module top_k_block_sum_ranker
    import tkbsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // apb configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [S_TDATA_WIDTH-1:0]  s_axis_tdata,  // [31:0] amount
    input  logic [0:0]                s_axis_tuser,  // [0] end_of_block
    input  logic                      s_axis_tlast,  // end_of_run
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [M_TDATA_WIDTH-1:0]  m_axis_tdata,  // [15:0] ranked_block_id, [51:16] ranked_sum
    output logic [0:0]                m_axis_tuser,  // [0] entry_valid
    output logic                      m_axis_tlast   // last
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_REPORT
    } t_state;

    t_state             r_state;
    logic [K_WIDTH-1:0] r_k;
    logic [K_WIDTH-1:0] w_k_eff;
    t_sum               r_acc;
    t_id                r_block_num;
    logic [SUM_WIDTH:0] w_acc_sum;
    t_sum               w_new_sum;
    t_id                w_new_id;
    t_cell_ctl          w_ctl;
    logic               w_in_xfer;
    logic               w_out_xfer;
    logic               w_cfg_wr;
    logic [MAX_RANKED-1:0] w_in_k;

    // chain wires, index i+1 is cell i, both ends tied off
    logic w_gt    [0:MAX_RANKED+1];
    logic w_valid [0:MAX_RANKED+1];
    t_sum w_sum   [0:MAX_RANKED+1];
    t_id  w_id    [0:MAX_RANKED+1];

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[APB_ADDR_WIDTH-1:2] == REG_K_IN_USE);
    assign prdata   = (paddr[APB_ADDR_WIDTH-1:2] == REG_K_IN_USE)
                      ? APB_DATA_WIDTH'(r_k) : '0;

    always_comb begin
        w_k_eff = r_k;
        if (r_k == '0) begin
            w_k_eff = K_WIDTH'(1);
        end else if (int'(r_k) > MAX_RANKED) begin
            w_k_eff = K_WIDTH'(MAX_RANKED);
        end
    end

    // handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_REPORT);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer    = m_axis_tvalid && m_axis_tready;

    // saturating block sum including this transfer's amount
    assign w_acc_sum = {1'b0, r_acc} + (SUM_WIDTH + 1)'(s_axis_tdata[AMOUNT_WIDTH-1:0]);
    assign w_new_sum = w_acc_sum[SUM_WIDTH] ? '1 : w_acc_sum[SUM_WIDTH-1:0];
    assign w_new_id  = r_block_num + ID_WIDTH'(1);

    assign w_ctl.accept = w_in_xfer;
    assign w_ctl.rank   = s_axis_tuser[0] || s_axis_tlast;
    assign w_ctl.shift  = w_out_xfer;

    assign w_gt[0]               = 1'b0;
    assign w_valid[0]            = 1'b1;
    assign w_sum[0]              = '0;
    assign w_id[0]               = '0;
    assign w_gt[MAX_RANKED+1]    = 1'b0;
    assign w_valid[MAX_RANKED+1] = 1'b0;
    assign w_sum[MAX_RANKED+1]   = '0;
    assign w_id[MAX_RANKED+1]    = '0;

    for (genvar gi = 0; gi < MAX_RANKED; gi++) begin : g_cell
        assign w_in_k[gi] = (int'(w_k_eff) > gi);

        tkbsr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_in_k       (w_in_k[gi]),
            .i_new_sum    (w_new_sum),
            .i_new_id     (w_new_id),
            .i_prev_gt    (w_gt[gi]),
            .i_prev_valid (w_valid[gi]),
            .i_prev_sum   (w_sum[gi]),
            .i_prev_id    (w_id[gi]),
            .i_next_valid (w_valid[gi+2]),
            .i_next_sum   (w_sum[gi+2]),
            .i_next_id    (w_id[gi+2]),
            .o_gt         (w_gt[gi+1]),
            .o_valid      (w_valid[gi+1]),
            .o_sum        (w_sum[gi+1]),
            .o_id         (w_id[gi+1])
        );
    end

    // head cell drives the result stream
    assign m_axis_tuser[0] = w_valid[1];
    assign m_axis_tdata    = w_valid[1] ? M_TDATA_WIDTH'({w_sum[1], w_id[1]}) : '0;
    assign m_axis_tlast    = !w_valid[1] || !w_valid[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= K_RESET;
            r_acc       <= '0;
            r_block_num <= '0;
        end else begin
            if (w_cfg_wr) begin
                r_k <= pwdata[K_WIDTH-1:0];
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        if (s_axis_tlast) begin
                            r_acc       <= '0;
                            r_block_num <= '0;
                            r_state     <= ST_REPORT;
                        end else if (s_axis_tuser[0]) begin
                            r_acc       <= '0;
                            r_block_num <= w_new_id;
                        end else begin
                            r_acc <= w_new_sum;
                        end
                    end
                end
                ST_REPORT: begin
                    if (w_out_xfer && m_axis_tlast) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/tkbsr_checker.sv
module tkbsr_checker
    import tkbsr_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      s_axis_tlast,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [M_TDATA_WIDTH-1:0]  m_axis_tdata,
    input logic [0:0]                m_axis_tuser,
    input logic                      m_axis_tlast
);

    // input side closed while a report is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open during report");

    // run end starts a report in the next cycle
    a_report_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("no report after run end");

    // final report transfer reopens the input side
    a_report_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not reopened after report");

    // empty-list result is a single zero transfer
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("malformed empty-list result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind top_k_block_sum_ranker tkbsr_checker u_tkbsr_checker (.*);
